[sv/lree_pkg.sv]
// Shared types and constants of the LR expression evaluator.
// Used by lr_expression_evaluator; depends on nothing.
package lree_pkg;

  localparam int STK_DEPTH = 64;
  localparam int STK_AW    = $clog2(STK_DEPTH);
  localparam int SP_W      = STK_AW + 1;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 4;
  localparam int OP_W      = 3;
  localparam int LIT_W     = 31;
  localparam int STAT_W    = 2;

  typedef enum logic [OP_W-1:0] {
    TOK_INT   = 3'd0,
    TOK_PLUS  = 3'd1,
    TOK_MULT  = 3'd2,
    TOK_OPEN  = 3'd3,
    TOK_CLOSE = 3'd4,
    TOK_END   = 3'd5
  } tok_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_PENDING  = 2'd0,
    STAT_ACCEPT   = 2'd1,
    STAT_SYNTAX   = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // LR automaton states as held on the state stack
  localparam logic [ST_W-1:0] LRS_START = 4'd0;
  localparam logic [ST_W-1:0] LRS_EXPR  = 4'd1;
  localparam logic [ST_W-1:0] LRS_OPEN  = 4'd2;
  localparam logic [ST_W-1:0] LRS_VAL   = 4'd3;
  localparam logic [ST_W-1:0] LRS_PLUS  = 4'd4;
  localparam logic [ST_W-1:0] LRS_TIMES = 4'd5;
  localparam logic [ST_W-1:0] LRS_PAR_E = 4'd6;
  localparam logic [ST_W-1:0] LRS_SUM   = 4'd7;
  localparam logic [ST_W-1:0] LRS_PROD  = 4'd8;
  localparam logic [ST_W-1:0] LRS_CLOSE = 4'd9;

  typedef enum logic [1:0] {
    RED_VAL = 2'd0,
    RED_ADD = 2'd1,
    RED_MUL = 2'd2,
    RED_PAR = 2'd3
  } red_e;

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_DECIDE = 4'b0010,
    FSM_READ   = 4'b0100,
    FSM_PUSH   = 4'b1000
  } fsm_e;

endpackage

[sv/lree_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Stands alone; holds the evaluator's state and value stacks.
module lree_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lr_expression_evaluator.sv]
// LR shift-reduce evaluator for E -> E+E | E*E | (E) | val.
// Depends on lree_pkg and lree_ram (state stack and value stack).
//
// Usage:
//   Tokens come in on the request channel (in_valid_i / in_stall_o) with
//   opcode_i and literal_i; one response per token leaves on the output
//   channel (out_valid_o / out_stall_i) with status_o and result_o.
//   Status is pending for a consumed token, accept (with the value) on
//   end, syntax error on a bad token, overflow when a shift finds the
//   stack full. After accept, error or overflow the stacks are emptied.
//
// Sequencing:
//   One request at a time. An accepted token moves from IDLE to DECIDE; each
//   reduction (at most three per token) then passes DECIDE, READ and PUSH:
//   issue the stack reads, read back and compute, goto and write back. The
//   response is registered from the last DECIDE (or from PUSH on a failed
//   goto), which waits for a free output register, then returns to IDLE.
//
// Reset empties the stacks at once (stack pointer to zero); memory contents
// are left as they are. A stalled response is held in the output register;
// the next request is still taken, and its response waits for the register.
module lr_expression_evaluator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lree_pkg::OP_W-1:0]   opcode_i,
  input  logic [lree_pkg::LIT_W-1:0]  literal_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lree_pkg::STAT_W-1:0] status_o,
  output logic signed [lree_pkg::VAL_W-1:0] result_o
);
  import lree_pkg::*;

  // sequencer and token registers
  fsm_e              fsm_q, fsm_d;
  logic [OP_W-1:0]   tok_q, tok_d;
  logic [LIT_W-1:0]  lit_q, lit_d;

  // stack pointer and cached top of stack
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [ST_W-1:0]   tos_state_q, tos_state_d;
  logic [VAL_W-1:0]  tos_val_q, tos_val_d;

  // reduction in flight
  red_e              red_kind_q, red_kind_d;
  logic [SP_W-1:0]   newsp_q, newsp_d;
  logic              src_zero_q, src_zero_d;
  logic [ST_W-1:0]   src_q, src_d;
  logic [VAL_W-1:0]  red_val_q, red_val_d;

  // response register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_result_q, out_result_d;
  logic              out_load;
  logic              out_free;

  // stack memory ports
  logic              mem_we;
  logic [STK_AW-1:0] mem_waddr;
  logic [ST_W-1:0]   st_wdata;
  logic [VAL_W-1:0]  val_wdata;
  logic [STK_AW-1:0] st_raddr;
  logic [STK_AW-1:0] val_raddr;
  logic [ST_W-1:0]   st_rdata;
  logic [VAL_W-1:0]  val_rdata;

  lree_ram #(
    .WIDTH (ST_W),
    .DEPTH (STK_DEPTH)
  ) u_state_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  lree_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STK_DEPTH)
  ) u_value_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // response register can take a new response this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (fsm_q != FSM_IDLE);

  always_comb begin
    logic            is_op;
    logic            do_shift;
    logic            do_reduce;
    logic            do_final;
    logic [ST_W-1:0] shift_st;
    logic [VAL_W-1:0] shift_val;
    status_e         fin_status;
    logic [VAL_W-1:0] fin_val;
    red_e            kind;
    logic            three;
    logic [SP_W-1:0] nsp;
    logic [ST_W-1:0] goto_st;
    logic            goto_ok;

    fsm_d        = fsm_q;
    tok_d        = tok_q;
    lit_d        = lit_q;
    sp_d         = sp_q;
    tos_state_d  = tos_state_q;
    tos_val_d    = tos_val_q;
    red_kind_d   = red_kind_q;
    newsp_d      = newsp_q;
    src_zero_d   = src_zero_q;
    src_d        = src_q;
    red_val_d    = red_val_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_result_d = out_result_q;
    mem_we       = 1'b0;
    mem_waddr    = sp_q[STK_AW-1:0];
    st_wdata     = tos_state_q;
    val_wdata    = tos_val_q;
    st_raddr     = '0;
    val_raddr    = '0;

    is_op      = (tok_q == TOK_PLUS) || (tok_q == TOK_MULT) ||
                 (tok_q == TOK_CLOSE) || (tok_q == TOK_END);
    do_shift   = 1'b0;
    do_reduce  = 1'b0;
    do_final   = 1'b0;
    shift_st   = LRS_START;
    shift_val  = '0;
    fin_status = STAT_SYNTAX;
    fin_val    = '0;
    kind       = RED_VAL;
    three      = 1'b0;
    nsp        = '0;
    goto_st    = LRS_EXPR;
    goto_ok    = 1'b1;

    case (fsm_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          tok_d = opcode_i;
          lit_d = literal_i;
          fsm_d = FSM_DECIDE;
        end
      end

      FSM_DECIDE: begin
        // action table of the automaton, keyed by the top state
        case (tos_state_q)
          LRS_START, LRS_OPEN, LRS_PLUS, LRS_TIMES: begin
            if (tok_q == TOK_INT) begin
              do_shift  = 1'b1;
              shift_st  = LRS_VAL;
              shift_val = VAL_W'(lit_q);
            end else if (tok_q == TOK_OPEN) begin
              do_shift = 1'b1;
              shift_st = LRS_OPEN;
            end
          end
          LRS_EXPR: begin
            if (tok_q == TOK_PLUS) begin
              do_shift = 1'b1;
              shift_st = LRS_PLUS;
            end else if (tok_q == TOK_MULT) begin
              do_shift = 1'b1;
              shift_st = LRS_TIMES;
            end else if (tok_q == TOK_END) begin
              do_final   = 1'b1;
              fin_status = STAT_ACCEPT;
              fin_val    = tos_val_q;
            end
          end
          LRS_VAL: begin
            if (is_op) begin
              do_reduce = 1'b1;
              kind      = RED_VAL;
            end
          end
          LRS_PAR_E: begin
            if (tok_q == TOK_PLUS) begin
              do_shift = 1'b1;
              shift_st = LRS_PLUS;
            end else if (tok_q == TOK_MULT) begin
              do_shift = 1'b1;
              shift_st = LRS_TIMES;
            end else if (tok_q == TOK_CLOSE) begin
              do_shift = 1'b1;
              shift_st = LRS_CLOSE;
            end
          end
          LRS_SUM: begin
            if (tok_q == TOK_MULT) begin
              do_shift = 1'b1;
              shift_st = LRS_TIMES;
            end else if (is_op) begin
              do_reduce = 1'b1;
              kind      = RED_ADD;
              three     = 1'b1;
            end
          end
          LRS_PROD: begin
            if (is_op) begin
              do_reduce = 1'b1;
              kind      = RED_MUL;
              three     = 1'b1;
            end
          end
          LRS_CLOSE: begin
            if (is_op) begin
              do_reduce = 1'b1;
              kind      = RED_PAR;
              three     = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (do_shift) begin
          do_final = 1'b1;
          if (sp_q == SP_W'(STK_DEPTH)) begin
            fin_status = STAT_OVERFLOW;
          end else begin
            fin_status = STAT_PENDING;
          end
        end else if (!do_reduce) begin
          do_final = 1'b1;
        end

        if (do_reduce) begin
          // pop one or three entries, then read the state left on top
          if (three) begin
            nsp = (sp_q >= SP_W'(3)) ? sp_q - SP_W'(3) : '0;
          end else begin
            nsp = (sp_q >= SP_W'(1)) ? sp_q - SP_W'(1) : '0;
          end
          newsp_d    = nsp;
          src_zero_d = (nsp == '0);
          red_kind_d = kind;
          st_raddr   = STK_AW'(nsp - SP_W'(1));
          if (kind == RED_PAR) begin
            val_raddr = STK_AW'(sp_q - SP_W'(2));
          end else begin
            val_raddr = STK_AW'(sp_q - SP_W'(3));
          end
          fsm_d = FSM_READ;
        end else if (do_final && out_free) begin
          out_load     = 1'b1;
          out_status_d = fin_status;
          out_result_d = fin_val;
          fsm_d        = FSM_IDLE;
          if (fin_status == STAT_PENDING) begin
            mem_we      = 1'b1;
            mem_waddr   = sp_q[STK_AW-1:0];
            st_wdata    = shift_st;
            val_wdata   = shift_val;
            sp_d        = sp_q + SP_W'(1);
            tos_state_d = shift_st;
            tos_val_d   = shift_val;
          end else begin
            sp_d        = '0;
            tos_state_d = LRS_START;
          end
        end
      end

      FSM_READ: begin
        // stack reads are back: form the reduced value
        src_d = src_zero_q ? LRS_START : st_rdata;
        case (red_kind_q)
          RED_VAL: red_val_d = tos_val_q;
          RED_ADD: red_val_d = val_rdata + tos_val_q;
          RED_MUL: red_val_d = VAL_W'(val_rdata * tos_val_q);
          RED_PAR: red_val_d = val_rdata;
          default: red_val_d = tos_val_q;
        endcase
        fsm_d = FSM_PUSH;
      end

      FSM_PUSH: begin
        // goto on E from the exposed state
        case (src_q)
          LRS_START: goto_st = LRS_EXPR;
          LRS_OPEN:  goto_st = LRS_PAR_E;
          LRS_PLUS:  goto_st = LRS_SUM;
          LRS_TIMES: goto_st = LRS_PROD;
          default:   goto_ok = 1'b0;
        endcase
        if (goto_ok) begin
          mem_we      = 1'b1;
          mem_waddr   = newsp_q[STK_AW-1:0];
          st_wdata    = goto_st;
          val_wdata   = red_val_q;
          sp_d        = newsp_q + SP_W'(1);
          tos_state_d = goto_st;
          tos_val_d   = red_val_q;
          fsm_d       = FSM_DECIDE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_status_d = STAT_SYNTAX;
          out_result_d = '0;
          sp_d         = '0;
          tos_state_d  = LRS_START;
          fsm_d        = FSM_IDLE;
        end
      end

      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase

    // response register: load, hold while stalled, drop once taken
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      sp_q        <= '0;
      tos_state_q <= LRS_START;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      sp_q        <= sp_d;
      tos_state_q <= tos_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q        <= tok_d;
    lit_q        <= lit_d;
    tos_val_q    <= tos_val_d;
    red_kind_q   <= red_kind_d;
    newsp_q      <= newsp_d;
    src_zero_q   <= src_zero_d;
    src_q        <= src_d;
    red_val_q    <= red_val_d;
    out_status_q <= out_status_d;
    out_result_q <= out_result_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign result_o    = out_result_q;

  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // an empty stack exposes the start state
  a_empty_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q == '0) |-> (tos_state_q == LRS_START))
    else $error("empty stack with non-start top state");

  // a closing response empties the stacks
  a_clear_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_status_d != STAT_PENDING)) |=> (sp_q == '0))
    else $error("stacks not emptied after accept or error");

  // value only travels with an accept
  a_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_ACCEPT)) |-> (result_o == '0))
    else $error("non-zero result without accept");

endmodule
